// ===== rtl/core/bsh_pkg.sv =====
// ----------------------------------------------------------------------------
// bsh_pkg
// Shared types and constants for the byte stream hash: the operation codes
// that the front end queues for the back end, and the queue entry layout.
// ----------------------------------------------------------------------------
package bsh_pkg;

  // Hash returned for an empty message
  localparam logic [31:0] EMPTY_HASH = 32'h1337c0de;

  // Input beat layout
  localparam int unsigned LEN_W   = 31;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned S_DATA_W = 40;  // length + byte, padded to whole bytes

  // Input kinds carried on tuser
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Operations handed from front to back
  typedef enum logic [2:0] {
    OP_SEED        = 3'd0,  // reseed running hash with length
    OP_EMPTY       = 3'd1,  // zero length message, answer at once
    OP_BLOCK       = 3'd2,  // full four byte block round
    OP_FINAL_TAIL  = 3'd3,  // 1..3 byte tail mix, then avalanche
    OP_FINAL_BLOCK = 3'd4   // last byte closes a block: round, then avalanche
  } op_code_t;

  typedef struct packed {
    op_code_t    code;
    logic [1:0]  count;  // tail size for OP_FINAL_TAIL
    logic [31:0] word;   // seed, or bytes little endian (byte 0 lowest)
  } op_t;

  // Queue write side, front to queue
  typedef struct packed {
    logic valid;
    op_t  op;
  } op_push_t;

endpackage

// ===== rtl/core/bsh_front.sv =====
// ----------------------------------------------------------------------------
// bsh_front
// Accepts input beats, gathers bytes into blocks and classifies each beat
// into at most one queued operation.
// ----------------------------------------------------------------------------
module bsh_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bsh_pkg::S_DATA_W-1:0]    s_axis_tdata,  // total_length, data_byte
  input  logic                            s_axis_tuser,  // kind
  input  logic                            s_axis_tlast,  // last
  input  logic                            q_full,
  output bsh_pkg::op_push_t               push
);

  logic [1:0]                    byte_position;
  logic [bsh_pkg::BYTE_W-1:0]    held [3];
  logic                          accept;
  logic [bsh_pkg::LEN_W-1:0]     total_length;
  logic [bsh_pkg::BYTE_W-1:0]    data_byte;
  logic [31:0]                   word;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign total_length  = s_axis_tdata[bsh_pkg::LEN_W-1:0];
  assign data_byte     = s_axis_tdata[bsh_pkg::LEN_W +: bsh_pkg::BYTE_W];

  // Block word with the new byte dropped in at the current position
  always_comb begin
    word[7:0]   = (byte_position == 2'd0) ? data_byte : held[0];
    word[15:8]  = (byte_position == 2'd1) ? data_byte : held[1];
    word[23:16] = (byte_position == 2'd2) ? data_byte : held[2];
    word[31:24] = data_byte;
  end

  // Classify the beat
  always_comb begin
    push.valid    = 1'b0;
    push.op.code  = bsh_pkg::OP_SEED;
    push.op.count = 2'd0;
    push.op.word  = word;
    if (accept) begin
      if (s_axis_tuser == bsh_pkg::KIND_START) begin
        push.valid   = 1'b1;
        push.op.code = (total_length == '0) ? bsh_pkg::OP_EMPTY : bsh_pkg::OP_SEED;
        push.op.word = {1'b0, total_length};
      end else if (byte_position == 2'd3) begin
        push.valid   = 1'b1;
        push.op.code = s_axis_tlast ? bsh_pkg::OP_FINAL_BLOCK : bsh_pkg::OP_BLOCK;
      end else if (s_axis_tlast) begin
        push.valid    = 1'b1;
        push.op.code  = bsh_pkg::OP_FINAL_TAIL;
        push.op.count = byte_position + 2'd1;
      end
    end
  end

  // Byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 2'd0;
    end else if (accept) begin
      if (s_axis_tuser == bsh_pkg::KIND_START || s_axis_tlast) begin
        byte_position <= 2'd0;
      end else begin
        byte_position <= byte_position + 2'd1;
      end
    end
  end

  // Held bytes of the open block
  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == bsh_pkg::KIND_DATA && byte_position != 2'd3) begin
      held[byte_position] <= data_byte;
    end
  end

endmodule

// ===== rtl/core/bsh_queue.sv =====
// ----------------------------------------------------------------------------
// bsh_queue
// Small FIFO of operations between the front and back ends.
// ----------------------------------------------------------------------------
module bsh_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  bsh_pkg::op_push_t   push,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output bsh_pkg::op_t        head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bsh_pkg::op_t       entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.op;
    end
  end

endmodule

// ===== rtl/core/bsh_back.sv =====
// ----------------------------------------------------------------------------
// bsh_back
// Executes queued operations on the running hash, then runs the avalanche
// over two stages into the output register.
// ----------------------------------------------------------------------------
module bsh_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  bsh_pkg::op_t    head,
  output logic            pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [31:0]     m_axis_tdata   // hash_value
);

  logic [31:0] running_hash;
  logic        advance;
  logic        take;
  logic [31:0] round_h;
  logic [31:0] tail_h;
  logic [31:0] fin_h;
  logic        v1;
  logic        raw1;
  logic [31:0] h1;
  logic        v2;
  logic        raw2;
  logic [31:0] h2;

  // Block round over two little-endian halves
  function automatic logic [31:0] block_round(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] x;
    x = h + {16'd0, w[15:0]};
    x = x ^ (x << 16) ^ ({16'd0, w[31:16]} << 11);
    x = x + (x >> 11);
    return x;
  endfunction

  // Tail mix for one, two or three left-over bytes
  function automatic logic [31:0] mix_tail(input logic [31:0] h, input logic [1:0] n,
                                           input logic [31:0] w);
    logic [31:0] x;
    x = h;
    unique case (n)
      2'd1: begin
        x = x + {24'd0, w[7:0]};
        x = x ^ (x << 10);
        x = x + (x >> 1);
      end
      2'd2: begin
        x = x + {16'd0, w[15:0]};
        x = x ^ (x << 11);
        x = x + (x >> 17);
      end
      2'd3: begin
        x = x + {16'd0, w[15:0]};
        x = x ^ (x << 16) ^ ({24'd0, w[23:16]} << 18);
        x = x + (x >> 11);
      end
      2'd0: x = h;
    endcase
    return x;
  endfunction

  // Avalanche, first half
  function automatic logic [31:0] aval_a(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h << 3);
    x = x + (x >> 5);
    x = x ^ (x << 2);
    return x;
  endfunction

  // Avalanche, second half
  function automatic logic [31:0] aval_b(input logic [31:0] h);
    logic [31:0] x;
    x = h + (h >> 15);
    x = x ^ (x << 10);
    return x;
  endfunction

  // Whole pipe moves when the output register is free or being taken
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign take    = advance && !q_empty;
  assign pop     = take;

  assign round_h = block_round(running_hash, head.word);
  assign tail_h  = mix_tail(running_hash, head.count, head.word);
  assign fin_h   = (head.code == bsh_pkg::OP_FINAL_BLOCK) ? round_h : tail_h;

  // Running hash
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (take) begin
      unique case (head.code)
        bsh_pkg::OP_SEED:        running_hash <= head.word;
        bsh_pkg::OP_BLOCK:       running_hash <= round_h;
        bsh_pkg::OP_EMPTY,
        bsh_pkg::OP_FINAL_TAIL,
        bsh_pkg::OP_FINAL_BLOCK: running_hash <= '0;
        default:                 running_hash <= running_hash;
      endcase
    end
  end

  // Stage valids and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      v1            <= take && (head.code == bsh_pkg::OP_EMPTY ||
                                head.code == bsh_pkg::OP_FINAL_TAIL ||
                                head.code == bsh_pkg::OP_FINAL_BLOCK);
      v2            <= v1;
      m_axis_tvalid <= v2;
    end
  end

  // Result payload; the empty answer skips the avalanche
  always_ff @(posedge clk) begin
    if (advance) begin
      raw1         <= (head.code == bsh_pkg::OP_EMPTY);
      h1           <= (head.code == bsh_pkg::OP_EMPTY) ? bsh_pkg::EMPTY_HASH : fin_h;
      raw2         <= raw1;
      h2           <= raw1 ? h1 : aval_a(h1);
      m_axis_tdata <= raw2 ? h2 : aval_b(h2);
    end
  end

endmodule

// ===== rtl/core/byte_stream_hash32.sv =====
// ----------------------------------------------------------------------------
// byte_stream_hash32
// 32-bit SuperFastHash style hash over a byte message streamed one byte a beat.
// ----------------------------------------------------------------------------
// Takes one input beat per clock cycle while the queue is not full. A start
// beat (tuser low) seeds the hash with the message length; a zero length
// answers 0x1337c0de. Each data beat (tuser high) carries one byte; the beat
// with tlast high closes the message and yields one 32-bit result. Its
// operation is written into the queue, then the result passes the hash
// update stage (h1) and the avalanche registers (h2, then the output).
// The sustained rate of one beat a cycle is set by the combinational block
// round on the running hash; the queue holds up to QUEUE_DEPTH operations
// while the output is stalled, and tready falls when it is full.
module byte_stream_hash32 #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bsh_pkg::S_DATA_W-1:0]  s_axis_tdata,  // [30:0] total_length, [38:31] data_byte
  input  logic                          s_axis_tuser,  // kind
  input  logic                          s_axis_tlast,  // last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata   // [31:0] hash_value
);

  bsh_pkg::op_push_t push;
  bsh_pkg::op_t      head;
  logic              q_full;
  logic              q_empty;
  logic              pop;

  // Front end: gather and classify
  bsh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .push          (push)
  );

  // Operation queue
  bsh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .head  (head)
  );

  // Back end: hash and avalanche
  bsh_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/core/bsh_checker.sv =====
// ----------------------------------------------------------------------------
// bsh_checker
// Port-level checks on the byte stream hash, bound to the top level.
// ----------------------------------------------------------------------------
module bsh_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed under stall");

  // Reset empties the result path
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Reset empties the queue, so input is ready right after
  a_rst_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

  // No result can appear sooner than the pipeline latency after reset
  a_latency: assert property (@(posedge clk)
    $rose(m_axis_tvalid) |-> !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3))
    else $error("result appeared too soon after reset");

endmodule

bind byte_stream_hash32 bsh_checker u_bsh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
